FILE: sv/spxc_pkg.sv
// shared types, constants and helpers for the seeded packet xor checker
package spxc_pkg;

    localparam int MAX_PACKET_BYTES = 2048;
    localparam int CNT_W            = $clog2(MAX_PACKET_BYTES + 1);
    localparam int LEN_W            = 12;
    localparam int SEED_W           = 16;
    localparam int WINDOW           = 9;
    localparam int TOTAL_W          = 32;

    localparam logic [SEED_W-1:0] SEED_RESET = 16'hDEEB;

    typedef enum logic [1:0] {
        VERDICT_VALID     = 2'd0,
        VERDICT_BAD_SEED  = 2'd1,
        VERDICT_CHECK_ERR = 2'd2,
        VERDICT_SHORT     = 2'd3
    } verdict_t;

    // packet summary including the beat that is being taken
    typedef struct packed {
        logic [SEED_W-1:0] seed;
        logic [7:0]        check_a;
        logic [7:0]        check_b;
        logic [7:0]        front_xor;
        logic [7:0]        tail_xor;
        logic [CNT_W-1:0]  len;
    } pkt_sum_t;

    function automatic logic [TOTAL_W-1:0] sat_add(input logic [TOTAL_W-1:0] a,
                                                    input logic [TOTAL_W-1:0] b);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    endfunction

endpackage

FILE: sv/spxc_frame.sv
// per-packet byte collector: seed, header checks, front xor and tail window
module spxc_frame (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output spxc_pkg::pkt_sum_t  sum
);

    localparam int CW = spxc_pkg::CNT_W;

    logic [15:0]   seed_reg, seed_next;
    logic [7:0]    check_a_reg, check_a_next;
    logic [7:0]    check_b_reg, check_b_next;
    logic [7:0]    front_reg, front_next;
    logic [7:0]    newest_reg, newest_next;
    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    recent_reg [spxc_pkg::WINDOW];
    logic [7:0]    recent_next [spxc_pkg::WINDOW];
    logic          keep;
    logic [7:0]    tail;

    assign keep = count_reg < CW'(spxc_pkg::MAX_PACKET_BYTES);

    always_comb
    begin
        seed_next    = seed_reg;
        check_a_next = check_a_reg;
        check_b_next = check_b_reg;
        front_next   = front_reg;
        newest_next  = newest_reg;
        count_next   = count_reg;
        for (int i = 0; i < spxc_pkg::WINDOW; i++)
        begin
            recent_next[i] = recent_reg[i];
        end
        if (keep)
        begin
            if (count_reg == CW'(0))
            begin
                seed_next = {data_byte, 8'h00};
            end
            else if (count_reg == CW'(1))
            begin
                seed_next = {seed_reg[15:8], data_byte};
            end
            else if (count_reg == CW'(2))
            begin
                check_a_next = data_byte;
            end
            else if (count_reg == CW'(3))
            begin
                check_b_next = data_byte;
            end
            if (count_reg >= CW'(4) && count_reg <= CW'(9))
            begin
                front_next = front_reg ^ data_byte;
            end
            // slide the window once a previous byte exists
            if (count_reg != CW'(0))
            begin
                for (int i = 0; i < spxc_pkg::WINDOW - 1; i++)
                begin
                    recent_next[i] = recent_reg[i+1];
                end
                recent_next[spxc_pkg::WINDOW-1] = newest_reg;
            end
            newest_next = data_byte;
            count_next  = count_reg + CW'(1);
        end
    end

    always_comb
    begin
        tail = 8'h00;
        for (int i = 0; i < spxc_pkg::WINDOW; i++)
        begin
            tail = tail ^ recent_next[i];
        end
    end

    assign sum.seed      = seed_next;
    assign sum.check_a   = check_a_next;
    assign sum.check_b   = check_b_next;
    assign sum.front_xor = front_next;
    assign sum.tail_xor  = tail;
    assign sum.len       = count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg    <= '0;
            check_a_reg <= '0;
            check_b_reg <= '0;
            front_reg   <= '0;
            newest_reg  <= '0;
            count_reg   <= '0;
            for (int i = 0; i < spxc_pkg::WINDOW; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else if (take)
        begin
            // end of packet clears everything for the next one
            if (last_byte)
            begin
                seed_reg    <= '0;
                check_a_reg <= '0;
                check_b_reg <= '0;
                front_reg   <= '0;
                newest_reg  <= '0;
                count_reg   <= '0;
                for (int i = 0; i < spxc_pkg::WINDOW; i++)
                begin
                    recent_reg[i] <= '0;
                end
            end
            else
            begin
                seed_reg    <= seed_next;
                check_a_reg <= check_a_next;
                check_b_reg <= check_b_next;
                front_reg   <= front_next;
                newest_reg  <= newest_next;
                count_reg   <= count_next;
                for (int i = 0; i < spxc_pkg::WINDOW; i++)
                begin
                    recent_reg[i] <= recent_next[i];
                end
            end
        end
    end

endmodule

FILE: sv/seeded_packet_xor_checker_unit.sv
// top level of the seeded packet xor checker: verdict, totals and result beat
// Takes one packet byte per beat and gives one result beat per packet, loaded
// when the beat that carries last_byte is taken. The packet state is updated
// and the verdict formed in a single pass of logic, and the result is held in
// an output register, so a new byte is taken every cycle while the result slot
// is empty or being drained. Bytes 0-1 are a big-endian seed that
// must equal the programmed seed, bytes 2-3 are two xor check bytes. For packets
// longer than 10 bytes the first check is the xor of bytes 4..9 and the second
// the xor of the nine bytes before the final one; shorter packets compare both
// checks against zero. Packets of fewer than four bytes get verdict 3 and leave
// the totals alone. Bytes past 2048 are dropped but the last marker still ends
// the packet. The four totals saturate at all ones and the result beat shows
// their value after this packet. The seed register may be written only while idle.
module seeded_packet_xor_checker_unit (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // byte input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  verdict,
    output logic [11:0] packet_length,
    output logic [31:0] out_valid_count,
    output logic [31:0] out_bad_seed_count,
    output logic [31:0] out_check_error_count,
    output logic [31:0] out_received_count
);

    localparam int CW = spxc_pkg::CNT_W;
    localparam int TW = spxc_pkg::TOTAL_W;

    logic                     take;
    logic                     finish;
    spxc_pkg::pkt_sum_t       sum;
    logic [15:0]              seed_reg;
    logic                     out_valid_reg, out_valid_next;
    spxc_pkg::verdict_t       verdict_reg, verdict_next;
    logic [11:0]              length_reg;
    logic [TW-1:0]            valid_tot_reg, valid_tot_next;
    logic [TW-1:0]            bad_seed_tot_reg, bad_seed_tot_next;
    logic [TW-1:0]            check_err_tot_reg, check_err_tot_next;
    logic [TW-1:0]            recv_tot_reg, recv_tot_next;
    logic [7:0]               calc_a, calc_b;

    // a byte may enter whenever the result slot is free or being emptied
    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;
    assign finish   = take && last_byte;

    spxc_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .sum       (sum)
    );

    // computed checks are zero up to ten bytes
    assign calc_a = (sum.len > CW'(10)) ? sum.front_xor : 8'h00;
    assign calc_b = (sum.len > CW'(10)) ? sum.tail_xor  : 8'h00;

    always_comb
    begin
        verdict_next       = spxc_pkg::VERDICT_SHORT;
        valid_tot_next     = valid_tot_reg;
        bad_seed_tot_next  = bad_seed_tot_reg;
        check_err_tot_next = check_err_tot_reg;
        recv_tot_next      = recv_tot_reg;
        if (sum.len >= CW'(4))
        begin
            recv_tot_next = spxc_pkg::sat_add(recv_tot_reg, TW'(sum.len));
            if (sum.seed != seed_reg)
            begin
                verdict_next      = spxc_pkg::VERDICT_BAD_SEED;
                bad_seed_tot_next = spxc_pkg::sat_add(bad_seed_tot_reg, TW'(1));
            end
            else if (calc_a == sum.check_a && calc_b == sum.check_b)
            begin
                verdict_next   = spxc_pkg::VERDICT_VALID;
                valid_tot_next = spxc_pkg::sat_add(valid_tot_reg, TW'(1));
            end
            else
            begin
                verdict_next       = spxc_pkg::VERDICT_CHECK_ERR;
                check_err_tot_next = spxc_pkg::sat_add(check_err_tot_reg, TW'(1));
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= spxc_pkg::SEED_RESET;
        end
        else if (cfg_we)
        begin
            seed_reg <= cfg_wdata;
        end
    end

    // totals double as the result beat's count fields: they only move when a
    // new result is loaded, so they hold steady while a beat is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            valid_tot_reg     <= '0;
            bad_seed_tot_reg  <= '0;
            check_err_tot_reg <= '0;
            recv_tot_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                valid_tot_reg     <= valid_tot_next;
                bad_seed_tot_reg  <= bad_seed_tot_next;
                check_err_tot_reg <= check_err_tot_next;
                recv_tot_reg      <= recv_tot_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            verdict_reg <= verdict_next;
            length_reg  <= sum.len[11:0];
        end
    end

    assign out_valid             = out_valid_reg;
    assign verdict               = verdict_reg;
    assign packet_length         = length_reg;
    assign out_valid_count       = valid_tot_reg;
    assign out_bad_seed_count    = bad_seed_tot_reg;
    assign out_check_error_count = check_err_tot_reg;
    assign out_received_count    = recv_tot_reg;

endmodule
